[rtl/ask_pkg.sv]
// Package for the angular-spectrum kernel: types, constants, CORDIC angle table.
`default_nettype none
package ask_pkg;
    localparam int HEIGHT = 512;
    localparam int WIDTH = 512;
    localparam int CORDIC_STEPS = 24;
    localparam int SQRT_STEPS = 32;
    localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
    localparam logic [50:0] ONE_Q50 = 51'h4_0000_0000_0000;

    localparam logic [1:0] REG_DIST = 2'd0;
    localparam logic [1:0] REG_ROW = 2'd1;
    localparam logic [1:0] REG_COL = 2'd2;

    typedef struct packed {
        logic [8:0] row;
        logic [8:0] col;
    } ask_in_t;

    typedef struct packed {
        logic signed [15:0] re_part;
        logic signed [15:0] im_part;
        logic               evanescent;
    } ask_out_t;

    // square-root chain payload
    typedef struct packed {
        logic        vld;
        logic        ev;
        logic [63:0] rem;
        logic [63:0] v;
        logic [31:0] root;
    } ask_sq_t;

    // CORDIC chain payload
    typedef struct packed {
        logic               vld;
        logic               ev;
        logic               flip;
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
    } ask_cr_t;

    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] t;
        case (i)
            0: t = 32'd536870912;   1: t = 32'd316933406;
            2: t = 32'd167458907;   3: t = 32'd85004756;
            4: t = 32'd42667331;    5: t = 32'd21354465;
            6: t = 32'd10679838;    7: t = 32'd5340245;
            8: t = 32'd2670163;     9: t = 32'd1335087;
            10: t = 32'd667544;     11: t = 32'd333772;
            12: t = 32'd166886;     13: t = 32'd83443;
            14: t = 32'd41722;      15: t = 32'd20861;
            16: t = 32'd10430;      17: t = 32'd5215;
            18: t = 32'd2608;       19: t = 32'd1304;
            20: t = 32'd652;        21: t = 32'd326;
            22: t = 32'd163;        default: t = 32'd81;
        endcase
        return t;
    endfunction
endpackage
`default_nettype wire

[rtl/ask_sqrt_cell.sv]
// One digit cell of the restoring square-root chain (one result bit per cell).
`default_nettype none
module ask_sqrt_cell (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire ask_pkg::ask_sq_t d_in,
    output ask_pkg::ask_sq_t      d_out
);
    import ask_pkg::*;
    ask_sq_t d_reg, d_next;
    logic [65:0] trial;
    logic [65:0] remx;

    always_comb begin
        d_next = d_in;
        // bring down the top two radicand bits, try root*4+1
        remx = {d_in.rem, d_in.v[63:62]};
        trial = {32'd0, d_in.root, 2'b01};
        d_next.v = {d_in.v[61:0], 2'b00};
        d_next.root = {d_in.root[30:0], 1'b0};
        d_next.rem = remx[63:0];
        if (remx >= trial) begin
            d_next.rem = 64'(remx - trial);
            d_next.root[0] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_reg.vld <= 1'b0;
        end else if (en) begin
            d_reg <= d_next;
        end
    end
    assign d_out = d_reg;
endmodule
`default_nettype wire

[rtl/ask_cordic_cell.sv]
// One rotation cell of the CORDIC chain.
`default_nettype none
module ask_cordic_cell (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire logic [4:0]       step,
    input  wire ask_pkg::ask_cr_t d_in,
    output ask_pkg::ask_cr_t      d_out
);
    import ask_pkg::*;
    ask_cr_t d_reg, d_next;
    logic signed [33:0] xs, ys, at;

    always_comb begin
        xs = d_in.x >>> step;
        ys = d_in.y >>> step;
        at = $signed({2'b00, atan_turn(int'(step))});
        d_next = d_in;
        if (!d_in.z[33]) begin
            d_next.x = d_in.x - ys;
            d_next.y = d_in.y + xs;
            d_next.z = d_in.z - at;
        end else begin
            d_next.x = d_in.x + ys;
            d_next.y = d_in.y - xs;
            d_next.z = d_in.z + at;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_reg.vld <= 1'b0;
        end else if (en) begin
            d_reg <= d_next;
        end
    end
    assign d_out = d_reg;
endmodule
`default_nettype wire

[rtl/angular_spectrum_kernel_core.sv]
// Top level: radicand, square-root chain, phase multiply, CORDIC chain, output.
//
// Angular-spectrum transfer function generator.
// s_valid/s_ready/s_data carry a (row, col) beat; m_valid/m_ready/m_data
// return {re_part, im_part, evanescent} in Q1.14. cfg_valid/cfg_ready with
// cfg_index/cfg_data write distance_over_wavelength (0), row_coeff (1),
// col_coeff (2); other indexes are ignored.
// One beat is accepted per cycle while the output is not stalled. Stages from
// input beat to output beat: 3 for squares, radicand products and compare, 32
// square-root cells (one root bit each), 3 for the split 44x32 phase multiply
// and angle, 24 CORDIC cells, 1 rounding and output register. The whole pipeline
// advances as one unit; when m_ready is low and the output holds a beat,
// the pipeline freezes and s_ready drops, otherwise beats flow back to back.
// Reset (synchronous, aresetn low) clears all valid bits and restores the
// register defaults. cfg_ready is always high.
`default_nettype none
module angular_spectrum_kernel_core (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire ask_pkg::ask_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output ask_pkg::ask_out_t      m_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [47:0]       cfg_data
);
    import ask_pkg::*;

    logic [43:0] dist_reg;
    logic [47:0] rowc_reg, colc_reg;
    logic en;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dist_reg <= '0;
            rowc_reg <= 48'd4299720;
            colc_reg <= 48'd4299720;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_DIST: dist_reg <= cfg_data[43:0];
                REG_ROW:  rowc_reg <= cfg_data;
                REG_COL:  colc_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign en = !m_valid || m_ready;
    assign s_ready = en;

    // stage 1: squared doubled offsets
    logic        v1_reg;
    logic [19:0] sr_reg, sc_reg;
    logic signed [10:0] dr, dc;
    always_comb begin
        dr = $signed({2'b00, s_data.row}) * 11'sd2 - 11'(HEIGHT);
        dc = $signed({2'b00, s_data.col}) * 11'sd2 - 11'(WIDTH);
    end
    // stage 2: coefficient products, split into halves
    logic        v2_reg;
    logic [43:0] pal_reg, pah_reg, pbl_reg, pbh_reg;
    // stage 3: sum and compare
    logic        v3_reg, ev3_reg;
    logic [63:0] rad3_reg;
    logic [69:0] pa, pb;
    logic [70:0] psum;
    always_comb begin
        pa = {26'd0, pal_reg} + {pah_reg, 24'd0};
        pb = {26'd0, pbl_reg} + {pbh_reg, 24'd0};
        psum = {1'b0, pa} + {1'b0, pb};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
        if (en) begin
            sr_reg <= 20'(dr * dr);
            sc_reg <= 20'(dc * dc);
            pal_reg <= 44'(rowc_reg[23:0] * sr_reg);
            pah_reg <= 44'(rowc_reg[47:24] * sr_reg);
            pbl_reg <= 44'(colc_reg[23:0] * sc_reg);
            pbh_reg <= 44'(colc_reg[47:24] * sc_reg);
            ev3_reg <= (psum > 71'(ONE_Q50));
            // radicand reaches 2^50 at the center, so it keeps all 51 bits
            rad3_reg <= {1'b0, 51'(ONE_Q50 - psum[50:0]), 12'd0};
        end
    end

    // square-root chain
    ask_sq_t sq [0:SQRT_STEPS];
    always_comb begin
        sq[0].vld = v3_reg;
        sq[0].ev = ev3_reg;
        sq[0].rem = '0;
        sq[0].v = rad3_reg;
        sq[0].root = '0;
    end
    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sq
        ask_sqrt_cell u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .d_in(sq[g]), .d_out(sq[g + 1]));
    end

    // phase multiply: dist (44) * root (32), in two 22x32 halves
    logic        v4_reg, ev4_reg, v5_reg, ev5_reg, v6_reg, ev6_reg;
    logic [53:0] ml_reg, mh_reg;
    logic [54:0] frac_reg;
    logic [31:0] ang_reg;
    logic [54:0] fsum;
    assign fsum = 55'(ml_reg) + 55'({mh_reg, 22'd0});
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= sq[SQRT_STEPS].vld;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
        if (en) begin
            ev4_reg <= sq[SQRT_STEPS].ev;
            ml_reg <= 54'(dist_reg[21:0] * sq[SQRT_STEPS].root);
            mh_reg <= 54'(dist_reg[43:22] * sq[SQRT_STEPS].root);
            ev5_reg <= ev4_reg;
            frac_reg <= fsum;
            ev6_reg <= ev5_reg;
            ang_reg <= frac_reg[54:23];
        end
    end

    // angle setup into CORDIC chain
    ask_cr_t cr [0:CORDIC_STEPS];
    logic        flip;
    logic [31:0] angf;
    function automatic logic angf_bit(input logic [31:0] a);
        logic [31:0] t;
        t = a + 32'h4000_0000;
        return t[31];
    endfunction
    always_comb begin
        flip = angf_bit(ang_reg);
        angf = flip ? (ang_reg - 32'h8000_0000) : ang_reg;
        cr[0].vld = v6_reg;
        cr[0].ev = ev6_reg;
        cr[0].flip = flip;
        cr[0].x = $signed({2'b00, CORDIC_GAIN_Q30});
        cr[0].y = '0;
        cr[0].z = $signed({{2{angf[31]}}, angf});
    end
    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cr
        ask_cordic_cell u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en), .step(5'(g)),
            .d_in(cr[g]), .d_out(cr[g + 1]));
    end

    // rounding, clamp, output register
    ask_cr_t cl;
    logic signed [33:0] xf, yf;
    logic signed [15:0] re_q, im_q;
    function automatic logic signed [15:0] to_q14(input logic signed [33:0] v);
        logic signed [34:0] r;
        logic signed [18:0] q;
        r = 35'(v) + 35'sd32768;
        q = 19'(r >>> 16);
        if (q > 19'sd16384) q = 19'sd16384;
        if (q < -19'sd16384) q = -19'sd16384;
        return q[15:0];
    endfunction
    always_comb begin
        cl = cr[CORDIC_STEPS];
        xf = cl.flip ? -cl.x : cl.x;
        yf = cl.flip ? -cl.y : cl.y;
        re_q = to_q14(xf);
        im_q = to_q14(yf);
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (en) begin
            m_valid <= cl.vld;
        end
        if (en) begin
            m_data.re_part <= cl.ev ? 16'sd0 : re_q;
            m_data.im_part <= cl.ev ? 16'sd0 : im_q;
            m_data.evanescent <= cl.ev;
        end
    end

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output beat changed while stalled");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready inconsistent with output stall");
    a_ev_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.evanescent |-> m_data.re_part == 16'sd0 &&
        m_data.im_part == 16'sd0)
        else $error("evanescent beat carries nonzero value");
endmodule
`default_nettype wire

[tb/angular_spectrum_kernel_core_tb.sv]
// Testbench for the angular-spectrum kernel core: directed and random pixels checked against a predictor.
`timescale 1ns / 1ps
module angular_spectrum_kernel_core_tb;
    import ask_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PIPE_DRAIN = 80;
    localparam int HOLD_CYCLES = 300;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    ask_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    ask_out_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = REG_DIST;
    logic [47:0] cfg_data = '0;

    always #6 aclk = ~aclk;

    angular_spectrum_kernel_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor copy of the registers
    logic [43:0] dist_q;
    logic [47:0] row_q;
    logic [47:0] col_q;

    ask_in_t pixel_q[$];
    ask_out_t kernel_q[$];
    int mismatches = 0;
    int idle_pct_s = 0;
    int idle_pct_m = 0;
    bit long_stall = 0;
    bit stall_done = 0;
    int hold_off = 0;
    int quiet_cycles = 0;
    bit timed_out = 0;

    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [15:0] round_q14(longint v);
        longint r;
        r = fshift(v + 32768, 16);
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return r[15:0];
    endfunction

    function automatic logic [31:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res[31:0];
    endfunction

    function automatic ask_out_t kernel_of(ask_in_t px);
        ask_out_t o;
        longint dr, dc;
        logic [127:0] pa, pb;
        logic [63:0] rad, s;
        logic [127:0] ph;
        logic [31:0] ang;
        logic flip;
        longint x, y, z, xs, ys;
        dr = 2 * longint'(px.row) - HEIGHT;
        dc = 2 * longint'(px.col) - WIDTH;
        pa = 128'(row_q) * 128'(dr * dr);
        pb = 128'(col_q) * 128'(dc * dc);
        o = '0;
        if (pa + pb > 128'(ONE_Q50)) begin
            o.evanescent = 1'b1;
            return o;
        end
        rad = 64'(ONE_Q50) - pa[63:0] - pb[63:0];
        s = int_sqrt(rad << 12);
        ph = 128'(dist_q) * 128'(s);
        ang = ph[54:23];
        flip = ang[31] ^ ang[30];
        if (flip) ang = ang - 32'h8000_0000;
        z = longint'($signed(ang));
        x = CORDIC_GAIN_Q30;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = fshift(x, i);
            ys = fshift(y, i);
            if (z >= 0) begin
                x -= ys; y += xs; z -= longint'(atan_turn(i));
            end else begin
                x += ys; y -= xs; z += longint'(atan_turn(i));
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        o.re_part = round_q14(x);
        o.im_part = round_q14(y);
        return o;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                kernel_q.push_back(kernel_of(s_data));
            end
            if (!s_valid || s_ready) begin
                if (pixel_q.size() > 0 && $urandom_range(99) >= idle_pct_s) begin
                    s_data <= pixel_q.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted in cycles
    always @(posedge aclk) begin
        if (long_stall && !stall_done) begin
            if (hold_off >= HOLD_CYCLES)
                stall_done <= 1'b1;
            else
                hold_off <= hold_off + 1;
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (kernel_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat %p", m_data);
                end else begin
                    ask_out_t e;
                    e = kernel_q.pop_front();
                    if (e.re_part !== m_data.re_part || e.im_part !== m_data.im_part ||
                        e.evanescent !== m_data.evanescent) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp re=%0d im=%0d ev=%0b got re=%0d im=%0d ev=%0b",
                                     e.re_part, e.im_part, e.evanescent,
                                     m_data.re_part, m_data.im_part, m_data.evanescent);
                    end
                end
            end
            if (long_stall && !stall_done) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= idle_pct_m);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1;
            $display("Verification failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [47:0] val);
        @(posedge aclk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_DIST: dist_q = val[43:0];
            REG_ROW: row_q = val;
            REG_COL: col_q = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pixel_q.size() > 0 || s_valid || kernel_q.size() > 0) @(posedge aclk);
        repeat (PIPE_DRAIN) @(posedge aclk);
    endtask

    function automatic ask_in_t rand_pixel();
        ask_in_t p;
        p.row = 9'($urandom_range(511));
        p.col = 9'($urandom_range(511));
        // mostly near the center so the propagating region dominates
        if ($urandom_range(3) != 0) begin
            p.row = 9'(256 + $urandom_range(80) - 40);
            p.col = 9'(256 + $urandom_range(80) - 40);
        end
        return p;
    endfunction

    task automatic run_random(input int n, input int ps, input int pm);
        idle_pct_s = ps;
        idle_pct_m = pm;
        repeat (n) pixel_q.push_back(rand_pixel());
        drain();
    endtask

    initial begin
        dist_q = '0;
        row_q = 48'd4299720;
        col_q = 48'd4299720;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: corners, center, edges, zero radicand, index outside the map
        pixel_q.push_back('{row: 9'd256, col: 9'd256});
        pixel_q.push_back('{row: 9'd0, col: 9'd0});
        pixel_q.push_back('{row: 9'd511, col: 9'd511});
        pixel_q.push_back('{row: 9'd0, col: 9'd511});
        pixel_q.push_back('{row: 9'd511, col: 9'd256});
        drain();
        write_reg(REG_DIST, 48'hFFF_FFFF_FFFF);
        write_reg(REG_ROW, 48'd0);
        write_reg(REG_COL, 48'd0);
        write_reg(2'd3, 48'hFFFF_FFFF_FFFF);
        pixel_q.push_back('{row: 9'd0, col: 9'd0});
        pixel_q.push_back('{row: 9'd256, col: 9'd256});
        pixel_q.push_back('{row: 9'd511, col: 9'd1});
        drain();
        // a=2^50/512^2: row 0 gives exactly zero radicand
        write_reg(REG_ROW, 48'h4000_0000_00 >> 6);
        write_reg(REG_COL, 48'hFFFF_FFFF_FFFF);
        write_reg(REG_DIST, 48'd123456789012);
        pixel_q.push_back('{row: 9'd0, col: 9'd256});
        pixel_q.push_back('{row: 9'd1, col: 9'd256});
        pixel_q.push_back('{row: 9'd256, col: 9'd257});
        pixel_q.push_back('{row: 9'd256, col: 9'd256});
        drain();

        // random phases with varied settings
        write_reg(REG_DIST, 48'(($urandom() << 12) | 32'hABC));
        write_reg(REG_ROW, 48'd4299720);
        write_reg(REG_COL, 48'd4299720);
        run_random(150, 0, 0);
        write_reg(REG_ROW, 48'd60000000);
        write_reg(REG_COL, 48'd90000000);
        run_random(150, 77, 0);
        write_reg(REG_DIST, 48'hFFF_FFFF_FFFF);
        run_random(150, 0, 77);
        write_reg(REG_DIST, 48'({$urandom(), 12'h5A5}));
        write_reg(REG_ROW, 48'd4299720);
        run_random(150, 10, 10);

        // long receiver hold-off while the sender keeps offering
        idle_pct_s = 0;
        idle_pct_m = 0;
        long_stall = 1'b1;
        run_random(150, 0, 0);

        if (mismatches == 0 && kernel_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
